/* rtl/core/b64e_pkg.sv */
// Package for the base64 stream encoder: group record, status record,
// padding and alphabet lookup. No dependencies.
package b64e_pkg;

	localparam int unsigned GROUP_CHARS = 4;
	localparam logic [6:0]  PAD_CHAR    = 7'd61;

	// One closed group, left aligned in 24 bits, with its byte count (1 to 3)
	typedef struct packed {
		logic [23:0] bits;
		logic [1:0]  nbytes;
		logic        last;
	} grp_t;

	// Queue status seen by front and back
	typedef struct packed {
		logic not_full;
		logic not_empty;
	} q_stat_t;

	// Map one sextet to its ASCII character in the standard alphabet
	function automatic logic [6:0] b64_char(input logic [5:0] v);
		logic [6:0] w;
		w = {1'b0, v};
		if (v < 6'd26) begin
			return 7'(w + 7'd65);
		end else if (v < 6'd52) begin
			return 7'(w + 7'd71);
		end else if (v < 6'd62) begin
			return 7'(w - 7'd4);
		end else if (v == 6'd62) begin
			return 7'd43;
		end else begin
			return 7'd47;
		end
	endfunction

endpackage

/* rtl/core/b64e_if.sv */
// Valid/ready channel interfaces for the base64 stream encoder:
// the byte channel in and the character channel out. No dependencies.
interface b64e_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       final_byte;

	modport source (output valid, output data_byte, output final_byte, input ready);
	modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b64e_char_if;
	logic       valid;
	logic       ready;
	logic [6:0] char_code;
	logic       group_end;
	logic       message_end;

	modport source (output valid, output char_code, output group_end, output message_end,
		input ready);
	modport sink   (input valid, input char_code, input group_end, input message_end,
		output ready);
endinterface

/* rtl/core/b64e_front.sv */
// Front end: accepts bytes, holds up to two, and closes a group on the third
// or final byte. Depends on b64e_pkg and b64e_byte_if.
module b64e_front import b64e_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	b64e_byte_if.sink        byte_ch,
	input  q_stat_t          stat,
	output logic             push,
	output grp_t             push_grp
);

	logic [15:0] pend_q;
	logic [1:0]  cnt_q;
	logic [1:0]  cnt_eff;
	logic        take;
	logic        close;

	assign byte_ch.ready = stat.not_full;
	assign take          = byte_ch.valid & byte_ch.ready;
	// a count of three cannot occur; treat it as two
	assign cnt_eff       = (cnt_q == 2'd3) ? 2'd2 : cnt_q;
	assign close         = byte_ch.final_byte | (cnt_eff == 2'd2);
	assign push          = take & close;

	// Pack the closing group left aligned
	always_comb begin
		push_grp.last   = byte_ch.final_byte;
		push_grp.nbytes = 2'(cnt_eff + 2'd1);
		case (cnt_eff)
			2'd0:    push_grp.bits = {byte_ch.data_byte, 16'h0000};
			2'd1:    push_grp.bits = {pend_q[15:8], byte_ch.data_byte, 8'h00};
			default: push_grp.bits = {pend_q, byte_ch.data_byte};
		endcase
	end

	// Hold pending bytes; clear the count when a group closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			cnt_q  <= '0;
		end else if (take) begin
			if (close) begin
				pend_q <= '0;
				cnt_q  <= '0;
			end else begin
				if (cnt_eff == 2'd0) begin
					pend_q <= {byte_ch.data_byte, 8'h00};
				end else begin
					pend_q <= {pend_q[15:8], byte_ch.data_byte};
				end
				cnt_q <= 2'(cnt_eff + 2'd1);
			end
		end
	end

endmodule

/* rtl/core/b64e_queue.sv */
// Short group queue between front and back, a ring of registers with a
// fill count. Depends on b64e_pkg.
module b64e_queue import b64e_pkg::*; #(
	parameter int unsigned DEPTH = 2
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  grp_t    push_grp,
	input  logic    pop,
	output grp_t    head,
	output q_stat_t stat
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	grp_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign head           = slot_q[rd_q];
	assign stat.not_full  = (cnt_q != FULL_CNT);
	assign stat.not_empty = (cnt_q != '0);

	// Write the entry at the tail
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_grp;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST_PTR) ? '0 : PTR_W'(wr_q + 1'b1);
			end
			if (pop) begin
				rd_q <= (rd_q == LAST_PTR) ? '0 : PTR_W'(rd_q + 1'b1);
			end
			if (push && !pop) begin
				cnt_q <= CNT_W'(cnt_q + 1'b1);
			end else if (pop && !push) begin
				cnt_q <= CNT_W'(cnt_q - 1'b1);
			end
		end
	end

endmodule

/* rtl/core/b64e_back.sv */
// Back end: walks the head group one character a cycle into an output register
// while char_ch.ready allows, padding short groups. Depends on b64e_pkg and b64e_char_if.
module b64e_back import b64e_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  grp_t         head,
	input  q_stat_t      stat,
	output logic         pop,
	b64e_char_if.source  char_ch
);

	logic [1:0] idx_q;
	logic       valid_q;
	logic [6:0] code_q;
	logic       gend_q;
	logic       mend_q;
	logic       load;
	logic [5:0] sextet;
	logic [6:0] code;
	logic       is_last_char;

	assign char_ch.valid       = valid_q;
	assign char_ch.char_code   = code_q;
	assign char_ch.group_end   = gend_q;
	assign char_ch.message_end = mend_q;

	assign load         = stat.not_empty & (~valid_q | char_ch.ready);
	assign is_last_char = (idx_q == 2'(GROUP_CHARS - 1));
	assign pop          = load & is_last_char;

	// Pick the sextet for the current place
	always_comb begin
		case (idx_q)
			2'd0:    sextet = head.bits[23:18];
			2'd1:    sextet = head.bits[17:12];
			2'd2:    sextet = head.bits[11:6];
			default: sextet = head.bits[5:0];
		endcase
	end

	// Places beyond the byte count carry padding
	assign code = (idx_q > head.nbytes) ? PAD_CHAR : b64_char(sextet);

	// Advance the place counter as characters load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= 2'(idx_q + 2'd1);
			end
			if (load) begin
				valid_q <= 1'b1;
			end else if (char_ch.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Output payload register
	always_ff @(posedge clk) begin
		if (load) begin
			code_q <= code;
			gend_q <= is_last_char;
			mend_q <= is_last_char & head.last;
		end
	end

endmodule

/* rtl/core/base64_stream_encoder.sv */
// Channel   | Dir | Payload                              | Accept
// byte_ch   | in  | data_byte[7:0], final_byte           | valid & ready
// char_ch   | out | char_code[6:0], group_end, message_end | valid & ready
//
// A byte is taken while byte_ch.ready is high; a group of up to three bytes leaves
// as four characters, one per cycle from the output register while char_ch.ready
// allows, so a full stream is limited by the single-character output port.
// Reset clears the pending bytes, the queue pointers and count, and the output valid flag.
// byte_ch.ready drops only while the group queue is full; the back end stalls
// on char_ch.ready without holding up the front until the queue fills.
// Top level of the base64 stream encoder. Depends on b64e_pkg, b64e_if,
// b64e_front, b64e_queue and b64e_back.
module base64_stream_encoder import b64e_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	b64e_byte_if.sink   byte_ch,
	b64e_char_if.source char_ch
);

	q_stat_t stat;
	logic    push;
	grp_t    push_grp;
	logic    pop;
	grp_t    head;

	b64e_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_ch  (byte_ch),
		.stat     (stat),
		.push     (push),
		.push_grp (push_grp)
	);

	b64e_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_grp (push_grp),
		.pop      (pop),
		.head     (head),
		.stat     (stat)
	);

	b64e_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.stat    (stat),
		.pop     (pop),
		.char_ch (char_ch)
	);

`ifndef SYNTHESIS
	// no group enters a full queue
	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> stat.not_full)
		else $error("group pushed into full queue");

	// no group leaves an empty queue
	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> stat.not_empty)
		else $error("group popped from empty queue");

	// a group popped this cycle shows its fourth character next cycle
	a_pop_group_end: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (char_ch.valid && char_ch.group_end))
		else $error("pop without group end on output");

	// message end only on a group end
	a_mend_in_group: assert property (@(posedge clk) disable iff (!arst_n)
		(char_ch.valid && char_ch.message_end) |-> char_ch.group_end)
		else $error("message end off a group end");
`endif

endmodule

/* tb/base64_stream_encoder_tb.sv */
`timescale 1ns / 1ps
// Testbench for base64_stream_encoder: streams messages of raw bytes in and checks every
// character against a built-in encoder model. Depends on b64e_pkg, b64e_if and the RTL.
module base64_stream_encoder_tb;
	import b64e_pkg::*;

	localparam int unsigned STALL_LIMIT  = 2000;
	localparam int unsigned DRAIN_CYCLES = 24;
	localparam int unsigned MAX_REPORTS  = 10;

	// Standard alphabet, entry 0 in the top byte
	localparam bit [0:63][7:0] ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	typedef struct packed {
		logic [6:0] code;
		logic       group_end;
		logic       message_end;
	} b64_char_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic char_ready = 1'b0;

	b64e_byte_if byte_ch ();
	b64e_char_if char_ch ();

	assign char_ch.ready = char_ready;

	base64_stream_encoder dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_ch (byte_ch),
		.char_ch (char_ch)
	);

	// Model state: bytes of the open group and how many are held
	logic [15:0] held_bytes = '0;
	logic [1:0]  held_count = '0;
	b64_char_t   expected_chars[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatches    = 0;
	int stall_cycles  = 0;

	always #2 clk = ~clk;

	// Hold a byte, or close the group and queue its four characters
	task automatic predict_encoding(input logic [7:0] b, input logic last);
		logic [1:0]  cnt;
		logic [23:0] group;
		int          nchars;
		b64_char_t   c;
		cnt = (held_count > 2'd2) ? 2'd2 : held_count;
		if (cnt < 2'd2 && !last) begin
			if (cnt == 2'd0) begin
				held_bytes = {b, 8'h00};
			end else begin
				held_bytes[7:0] = b;
			end
			held_count = cnt + 2'd1;
		end else begin
			case (cnt)
				2'd0:    group = {b, 16'h0000};
				2'd1:    group = {held_bytes[15:8], b, 8'h00};
				default: group = {held_bytes, b};
			endcase
			nchars = int'(cnt) + 2;
			for (int k = 0; k < 4; k++) begin
				if (k < nchars) begin
					c.code = ALPHABET[group[23 - 6 * k -: 6]][6:0];
				end else begin
					c.code = PAD_CHAR;
				end
				c.group_end   = (k == 3);
				c.message_end = (k == 3) && last;
				expected_chars.push_back(c);
			end
			held_bytes = '0;
			held_count = '0;
		end
	endtask

	task automatic note_mismatch(input string detail);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("%0t: mismatch: %s", $realtime, detail);
		end
	endtask

	// Predict on accepted bytes, check accepted characters, stall the receiver
	always @(posedge clk) begin
		if (arst_n) begin
			if (byte_ch.valid && byte_ch.ready) begin
				predict_encoding(byte_ch.data_byte, byte_ch.final_byte);
			end
			if (char_ch.valid && char_ch.ready) begin
				if (expected_chars.size() == 0) begin
					note_mismatch($sformatf("unexpected char code %0d ge %0b me %0b",
						char_ch.char_code, char_ch.group_end, char_ch.message_end));
				end else begin
					if (char_ch.char_code !== expected_chars[0].code ||
							char_ch.group_end !== expected_chars[0].group_end ||
							char_ch.message_end !== expected_chars[0].message_end) begin
						note_mismatch($sformatf(
							"expected code %0d ge %0b me %0b, got code %0d ge %0b me %0b",
							expected_chars[0].code, expected_chars[0].group_end,
							expected_chars[0].message_end, char_ch.char_code,
							char_ch.group_end, char_ch.message_end));
					end
					void'(expected_chars.pop_front());
				end
			end
			if ((byte_ch.valid && byte_ch.ready) || (char_ch.valid && char_ch.ready)) begin
				stall_cycles <= 0;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
		char_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// End the run when nothing moves for too long
	initial begin : watchdog
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
		end
		$display("base64_stream_encoder_tb: FAIL");
		$finish;
	end

	// Offer one item and hold it until it is taken
	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			byte_ch.valid <= 1'b0;
			@(posedge clk);
		end
		byte_ch.valid      <= 1'b1;
		byte_ch.data_byte  <= b;
		byte_ch.final_byte <= last;
		@(posedge clk);
		while (!byte_ch.ready) begin
			@(posedge clk);
		end
	endtask

	// Short final groups: one byte gives two pads, two bytes give one
	task automatic test_padded_groups();
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h55, 1'b0);
		send_byte(8'hAA, 1'b1);
	endtask

	// Full groups, with and without the final flag on the third byte, and a one-byte final group
	task automatic test_full_groups();
		send_byte(8'hFB, 1'b0);
		send_byte(8'hEF, 1'b0);
		send_byte(8'hBE, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'h10, 1'b0);
		send_byte(8'h83, 1'b1);
		send_byte(8'hF8, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h01, 1'b1);
	endtask

	// Random messages, mostly short, now and then a longer one
	task automatic test_random_messages(input int send_pct, input int recv_pct,
			input int nbytes);
		int sent;
		int len;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		sent = 0;
		while (sent < nbytes) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 7);
			for (int i = 0; i < len; i++) begin
				send_byte(8'($urandom_range(0, 255)), i == len - 1);
			end
			sent += len;
		end
	endtask

	initial begin
		byte_ch.valid      = 1'b0;
		byte_ch.data_byte  = '0;
		byte_ch.final_byte = 1'b0;
		send_idle_pct = 26;
		recv_idle_pct = 52;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_padded_groups();
		test_full_groups();
		test_random_messages(26, 52, 33);
		test_random_messages(52, 26, 33);
		test_random_messages(0, 0, 33);

		// Drop valid, drain the outstanding characters, then let the block settle
		byte_ch.valid <= 1'b0;
		while (expected_chars.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && expected_chars.size() == 0) begin
			$display("base64_stream_encoder_tb: PASS");
		end else begin
			$display("base64_stream_encoder_tb: FAIL");
		end
		$finish;
	end

endmodule
